/* hdl/rstt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rstt_pkg
// Shared types and constants of the repeating software timer table.
// ----------------------------------------------------------------------------
package rstt_pkg;

  localparam int TimerSlots = 16;

  typedef enum logic [2:0] {
    OP_ATTACH  = 3'd0,
    OP_REPLACE = 3'd1,
    OP_DETACH  = 3'd2,
    OP_KILL    = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    KIND_ID   = 3'd0,
    KIND_ACK  = 3'd1,
    KIND_KILL = 3'd2,
    KIND_FIRE = 3'd3,
    KIND_DONE = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] handler;
    logic [31:0] timeout_ms;
    logic [7:0]  repeat_count;
    logic [31:0] user_word;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] timer_id;
    logic [15:0] fired_handler;
    logic [31:0] fired_word;
    logic        found;
    logic        full_res;
    logic        last;
  } res_t;

  // one timer entry as held in memory
  typedef struct packed {
    logic [15:0] handler;
    logic [31:0] word;
    logic [31:0] id;
    logic [31:0] timeout;
    logic [7:0]  repeats;
    logic [31:0] age;
    logic        killed;
  } entry_t;

endpackage
`default_nettype wire

/* hdl/rstt_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rstt_req_if / rstt_res_if
// Valid/ready channels carrying requests and result words.
// ----------------------------------------------------------------------------
interface rstt_req_if;
  logic valid;
  logic ready;
  rstt_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rstt_res_if;
  logic valid;
  logic ready;
  rstt_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/repeating_software_timer_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// repeating_software_timer_table
// Ordered table of repeating timers with pending attach and detach queues.
// ----------------------------------------------------------------------------
// One request is handled at a time. Attach, detach and unused codes are
// answered straight from idle. Kill scans the table, reading each running
// entry in S_KILL and comparing it in S_KILLW. A tick walks the table memory
// through a single read/modify/write port: it fires and compacts the running
// entries, ages the pending entries, removes dropped handlers, joins the
// pending queue and sends a done word. Results leave through a one-word
// output register, so a fire word waits only while the output is stalled.
module repeating_software_timer_table #(
  parameter int TIMER_SLOTS = rstt_pkg::TimerSlots
) (
  input  wire  clk,
  input  wire  rst,
  rstt_req_if.sink   req,
  rstt_res_if.source res
);

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam logic [CW-1:0] FULL = CW'(TIMER_SLOTS);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_KILL  = 10'b0000000010,
    S_PAGE  = 10'b0000000100,
    S_FIRE  = 10'b0000001000,
    S_DROP  = 10'b0000010000,
    S_SHIFT = 10'b0000100000,
    S_JOIN  = 10'b0001000000,
    S_DONE  = 10'b0010000000,
    S_KILLW = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_t;

  state_t state;

  // memories: running table and pending queues
  rstt_pkg::entry_t run_mem [TIMER_SLOTS];
  rstt_pkg::entry_t pend_mem [TIMER_SLOTS];
  logic [15:0] drop_mem [TIMER_SLOTS];

  logic [CW-1:0] run_count, pend_count, drop_count;
  logic [31:0] next_id;

  rstt_pkg::req_t cur;
  logic [CW-1:0] ri, wi, di, si;
  logic full_flag;
  logic rd_ok;
  rstt_pkg::entry_t rd_run, rd_pend;
  logic [15:0] rd_drop;

  // read address driven from state
  logic [IW-1:0] run_ra, pend_ra, drop_ra;

  logic out_valid;
  rstt_pkg::res_t out_data;
  logic out_free;

  assign out_free  = !out_valid || res.ready;
  assign res.valid = out_valid;
  assign res.data  = out_data;
  assign req.ready = (state == S_IDLE) && out_free;

  always_comb begin
    run_ra  = ri[IW-1:0];
    pend_ra = ri[IW-1:0];
    drop_ra = di[IW-1:0];
  end

  always_ff @(posedge clk) begin
    rd_run  <= run_mem[run_ra];
    rd_pend <= pend_mem[pend_ra];
    rd_drop <= drop_mem[drop_ra];
  end

  // aged and fire decision of entry just read
  rstt_pkg::entry_t aged;
  logic fire, keep;
  logic [7:0] rep_dec;
  always_comb begin
    aged = rd_run;
    if (aged.age != '1) aged.age = aged.age + 32'd1;
    fire = !aged.killed && (aged.age >= aged.timeout);
    rep_dec = aged.repeats;
    if (!rep_dec[7] && rep_dec != 8'd0) rep_dec = rep_dec - 8'd1;
    keep = !fire || (rep_dec != 8'd0);
    if (fire) begin
      aged.repeats = rep_dec;
      aged.age = '0;
    end
  end

  function automatic rstt_pkg::res_t mk(input logic [2:0] k, input logic [31:0] id,
                                         input logic [15:0] h, input logic [31:0] w,
                                         input logic f, input logic fl,
                                         input logic l);
    rstt_pkg::res_t r;
    r.kind = k; r.timer_id = id; r.fired_handler = h; r.fired_word = w;
    r.found = f; r.full_res = fl; r.last = l;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      run_count <= '0;
      pend_count <= '0;
      drop_count <= '0;
      next_id <= '0;
      ri <= '0; wi <= '0; di <= '0; si <= '0;
      rd_ok <= 1'b0;
      full_flag <= 1'b0;
    end else begin
      if (res.ready) out_valid <= 1'b0;
      rd_ok <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid && out_free) begin
            cur <= req.data;
            ri <= '0; wi <= '0; di <= '0;
            full_flag <= 1'b0;
            out_valid <= 1'b1;
            case (req.data.op)
              rstt_pkg::OP_ATTACH, rstt_pkg::OP_REPLACE: begin
                logic dfull;
                dfull = 1'b0;
                if (req.data.op == rstt_pkg::OP_REPLACE) begin
                  if (drop_count == FULL) dfull = 1'b1;
                  else begin
                    drop_mem[drop_count[IW-1:0]] <= req.data.handler;
                    drop_count <= drop_count + CW'(1);
                  end
                end
                if (pend_count == FULL) begin
                  out_data <= mk(rstt_pkg::KIND_ID, '0, '0, '0, 1'b0, 1'b1, 1'b1);
                end else begin
                  pend_mem[pend_count[IW-1:0]] <= '{handler: req.data.handler,
                    word: req.data.user_word, id: next_id,
                    timeout: req.data.timeout_ms, repeats: req.data.repeat_count,
                    age: 32'd0, killed: 1'b0};
                  pend_count <= pend_count + CW'(1);
                  next_id <= next_id + 32'd1;
                  out_data <= mk(rstt_pkg::KIND_ID, next_id, '0, '0, 1'b0, dfull, 1'b1);
                end
              end
              rstt_pkg::OP_DETACH: begin
                if (drop_count == FULL) begin
                  out_data <= mk(rstt_pkg::KIND_ACK, '0, '0, '0, 1'b0, 1'b1, 1'b1);
                end else begin
                  drop_mem[drop_count[IW-1:0]] <= req.data.handler;
                  drop_count <= drop_count + CW'(1);
                  out_data <= mk(rstt_pkg::KIND_ACK, '0, '0, '0, 1'b0, 1'b0, 1'b1);
                end
              end
              rstt_pkg::OP_KILL: begin
                out_valid <= 1'b0;
                state <= S_KILL;
              end
              rstt_pkg::OP_TICK: begin
                out_valid <= 1'b0;
                state <= S_FIRE;
              end
              default: begin
                out_data <= mk(rstt_pkg::KIND_ACK, '0, '0, '0, 1'b0, 1'b0, 1'b1);
              end
            endcase
          end
        end
        // kill: read one entry here, compare it in S_KILLW
        S_KILL: begin
          if (ri == run_count) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_data <= mk(rstt_pkg::KIND_KILL, '0, '0, '0, 1'b0, 1'b0, 1'b1);
              state <= S_IDLE;
            end
          end else begin
            state <= S_KILLW;
          end
        end
        S_KILLW: begin
          if (rd_run.handler == cur.handler) begin
            if (out_free) begin
              run_mem[ri[IW-1:0]] <= '{handler: rd_run.handler, word: rd_run.word,
                id: rd_run.id, timeout: rd_run.timeout, repeats: rd_run.repeats,
                age: rd_run.age, killed: 1'b1};
              out_valid <= 1'b1;
              out_data <= mk(rstt_pkg::KIND_KILL, '0, '0, '0, 1'b1, 1'b0, 1'b1);
              state <= S_IDLE;
            end
          end else begin
            ri <= ri + CW'(1);
            state <= S_KILL;
          end
        end
        // fire pass: read ri, compact into wi
        S_FIRE: begin
          if (ri == run_count) begin
            run_count <= wi;
            ri <= '0;
            state <= S_PAGE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!fire || out_free) begin
            if (fire) begin
              out_valid <= 1'b1;
              out_data <= mk(rstt_pkg::KIND_FIRE, aged.id, aged.handler, aged.word,
                             1'b0, 1'b0, 1'b0);
            end
            if (keep) begin
              run_mem[wi[IW-1:0]] <= aged;
              wi <= wi + CW'(1);
            end
            ri <= ri + CW'(1);
            state <= S_FIRE;
          end
        end
        // age pending entries
        S_PAGE: begin
          if (ri == pend_count) begin
            ri <= '0;
            di <= '0;
            state <= S_DROP;
          end else if (rd_ok) begin
            if (rd_pend.age != '1)
              pend_mem[ri[IW-1:0]] <= '{handler: rd_pend.handler, word: rd_pend.word,
                id: rd_pend.id, timeout: rd_pend.timeout, repeats: rd_pend.repeats,
                age: rd_pend.age + 32'd1, killed: 1'b0};
            ri <= ri + CW'(1);
          end else begin
            rd_ok <= 1'b1;
          end
        end
        // detach: search drop di in table
        S_DROP: begin
          if (di == drop_count) begin
            drop_count <= '0;
            ri <= '0;
            state <= S_JOIN;
          end else if (ri == run_count) begin
            di <= di + CW'(1);
            ri <= '0;
          end else if (rd_ok) begin
            if (rd_run.handler == rd_drop) begin
              // point the read at the entry that moves down first
              si <= ri;
              ri <= ri + CW'(1);
              state <= S_SHIFT;
            end else begin
              ri <= ri + CW'(1);
            end
          end else begin
            rd_ok <= 1'b1;
          end
        end
        // move entries down over the removed one
        S_SHIFT: begin
          if (si + CW'(1) >= run_count) begin
            run_count <= run_count - CW'(1);
            di <= di + CW'(1);
            ri <= '0;
            state <= S_DROP;
          end else if (rd_ok) begin
            run_mem[si[IW-1:0]] <= rd_run;
            si <= si + CW'(1);
            ri <= si + CW'(2);
          end else begin
            ri <= si + CW'(1);
            rd_ok <= 1'b1;
          end
        end
        S_JOIN: begin
          if (ri == pend_count) begin
            pend_count <= '0;
            state <= S_DONE;
          end else if (rd_ok) begin
            if (run_count == FULL) full_flag <= 1'b1;
            else begin
              run_mem[run_count[IW-1:0]] <= rd_pend;
              run_count <= run_count + CW'(1);
            end
            ri <= ri + CW'(1);
          end else begin
            rd_ok <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data <= mk(rstt_pkg::KIND_DONE, '0, '0, '0, 1'b0, full_flag, 1'b1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // read addresses for the shift step are ri; the pending pass reads ri
  a_counts: assert property (@(posedge clk) disable iff (rst)
    run_count <= FULL && pend_count <= FULL && drop_count <= FULL)
    else $error("count beyond table size");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !req.ready)
    else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == rstt_pkg::KIND_FIRE |-> !out_data.last)
    else $error("fire word marked last");

endmodule
`default_nettype wire
